### rtl/rlbs_pkg.sv
// ----------------------------------------------------------------------------
// rlbs_pkg
// shared types and constants for the rgbw led bit serializer
// ----------------------------------------------------------------------------
package rlbs_pkg;

    localparam int CHAN_W        = 8;
    localparam int PROD_W        = 2 * CHAN_W;
    localparam int NUM_CHAN      = 4;
    localparam int WORD_W        = NUM_CHAN * CHAN_W;
    localparam int CNT_W         = $clog2(WORD_W + 1);

    // divide by 100 as multiply by ceil(2^19 / 100) then shift, exact for every
    // product below 43690, and any larger product saturates to full scale anyway
    localparam int RECIP_W       = 13;
    localparam int RECIP_SHIFT   = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
    localparam int QUOT_W        = PROD_W + RECIP_W - RECIP_SHIFT;

    localparam logic [CHAN_W-1:0] BRIGHT_RESET = CHAN_W'(20);
    localparam logic [CHAN_W-1:0] CHAN_MAX     = '1;

    typedef enum logic [1:0] {
        SYM_ZERO = 2'd0,
        SYM_ONE  = 2'd1,
        SYM_GAP  = 2'd2
    } t_sym;

endpackage

### rtl/rlbs_pix_if.sv
// ----------------------------------------------------------------------------
// rlbs_pix_if
// pixel channel: valid/ready handshake with four color bytes and frame mark
// ----------------------------------------------------------------------------
interface rlbs_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
    logic       end_of_frame;

    modport source (output valid, red, green, blue, white, end_of_frame, input ready);
    modport sink   (input valid, red, green, blue, white, end_of_frame, output ready);
endinterface

### rtl/rlbs_sym_if.sv
// ----------------------------------------------------------------------------
// rlbs_sym_if
// line symbol channel: valid/ready handshake with symbol code and last flag
// ----------------------------------------------------------------------------
interface rlbs_sym_if;
    logic       valid;
    logic       ready;
    logic [1:0] symbol;
    logic       last;

    modport source (output valid, symbol, last, input ready);
    modport sink   (input valid, symbol, last, output ready);
endinterface

### rtl/rlbs_scale_lane.sv
// ----------------------------------------------------------------------------
// rlbs_scale_lane
// one color channel: level * brightness / 100, saturated to one byte
// ----------------------------------------------------------------------------
module rlbs_scale_lane (
    input  logic                         i_clk,
    input  logic                         i_en1,
    input  logic                         i_en2,
    input  logic [rlbs_pkg::CHAN_W-1:0]  i_level,
    input  logic [rlbs_pkg::CHAN_W-1:0]  i_bright,
    output logic [rlbs_pkg::CHAN_W-1:0]  o_byte
);
    import rlbs_pkg::*;

    logic [PROD_W-1:0]           r_prod;
    logic [PROD_W+RECIP_W-1:0]   n_recip;
    logic [QUOT_W-1:0]           n_quot;
    logic [CHAN_W-1:0]           n_byte;
    logic [CHAN_W-1:0]           r_byte;

    always_comb begin
        n_recip = PROD_W'(r_prod) * (PROD_W+RECIP_W)'(RECIP_100);
        n_quot  = n_recip[PROD_W+RECIP_W-1:RECIP_SHIFT];
        if (n_quot > QUOT_W'(CHAN_MAX)) begin
            n_byte = CHAN_MAX;
        end else begin
            n_byte = n_quot[CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_prod <= PROD_W'(i_level) * PROD_W'(i_bright);
        end
        if (i_en2) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

### rtl/rlbs_serializer.sv
// ----------------------------------------------------------------------------
// rlbs_serializer
// merges the four lane bytes into one grbw word and shifts it out msb first
// ----------------------------------------------------------------------------
module rlbs_serializer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_word_valid,
    input  logic [rlbs_pkg::CHAN_W-1:0]   i_green,
    input  logic [rlbs_pkg::CHAN_W-1:0]   i_red,
    input  logic [rlbs_pkg::CHAN_W-1:0]   i_blue,
    input  logic [rlbs_pkg::CHAN_W-1:0]   i_white,
    input  logic                          i_eof,
    output logic                          o_word_take,
    rlbs_sym_if.source                    o_sym
);
    import rlbs_pkg::*;

    logic [WORD_W-1:0] r_word, n_word;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_eof, n_eof;
    logic              r_busy, n_busy;
    logic              last_sym;
    logic              fire;
    logic              take;

    // last symbol: final data bit of a plain pixel, or the gap after a frame end
    assign last_sym = r_eof ? (r_cnt == CNT_W'(WORD_W))
                            : (r_cnt == CNT_W'(WORD_W - 1));
    assign fire     = r_busy && o_sym.ready;
    assign take     = i_word_valid && (!r_busy || (fire && last_sym));

    always_comb begin
        n_word = r_word;
        n_cnt  = r_cnt;
        n_eof  = r_eof;
        n_busy = r_busy;
        if (take) begin
            n_word = {i_green, i_red, i_blue, i_white};
            n_cnt  = '0;
            n_eof  = i_eof;
            n_busy = 1'b1;
        end else if (fire) begin
            if (last_sym) begin
                n_busy = 1'b0;
            end else begin
                n_word = {r_word[WORD_W-2:0], 1'b0};
                n_cnt  = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_eof  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_eof  <= n_eof;
        end
        r_word <= n_word;
    end

    assign o_word_take  = take;
    assign o_sym.valid  = r_busy;
    assign o_sym.last   = last_sym;
    assign o_sym.symbol = (r_cnt == CNT_W'(WORD_W)) ? SYM_GAP
                        : (r_word[WORD_W-1] ? SYM_ONE : SYM_ZERO);

endmodule

### rtl/rgbw_led_bit_serializer_core.sv
// ----------------------------------------------------------------------------
// rgbw_led_bit_serializer_core
// scales an rgbw pixel by a brightness percentage and serializes it into
// line symbols for an addressable led strip
// ----------------------------------------------------------------------------
//
//  port          dir   beat contents
//  ------------  ----  ------------------------------------------------------
//  i_pix         sink  red, green, blue, white bytes and end_of_frame mark
//  o_sym         src   symbol (zero bit, one bit, reset gap) and last flag
//  i_cfg_we/wd   in    brightness percentage, written while idle
//
//  each pixel yields 32 symbol beats (33 with end_of_frame), one per cycle
//  while o_sym.ready is high; the serializer's shift register sets that rate
//  a pixel's first symbol beat is offered after it has passed the product
//  registers, the scaled-byte registers and then the serializer, and a stall
//  can hold it in a lane stage; the lane stages buffer the next two pixels
//  synchronous active-low reset empties the pipeline and sets brightness to 20
//  a stall on o_sym holds the current symbol; i_pix.ready drops once both
//  lane stages are full and no word is taken, and stays low during reset
// ----------------------------------------------------------------------------
module rgbw_led_bit_serializer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rlbs_pkg::CHAN_W-1:0]   i_cfg_wdata,
    rlbs_pix_if.sink                      i_pix,
    rlbs_sym_if.source                    o_sym
);
    import rlbs_pkg::*;

    // brightness register
    logic [CHAN_W-1:0] r_bright;

    // pipeline control: stage 1 holds products, stage 2 holds scaled bytes
    logic              r_v1, r_v2;
    logic              r_eof1, r_eof2;
    logic              en1, en2;
    logic              word_take;

    // lane outputs in lane order red, green, blue, white
    logic [CHAN_W-1:0] lane_byte [NUM_CHAN];
    logic [CHAN_W-1:0] lane_level [NUM_CHAN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= BRIGHT_RESET;
        end else if (i_cfg_we) begin
            r_bright <= i_cfg_wdata;
        end
    end

    // a stage loads when it is empty or its content moves on this cycle
    assign en2         = !r_v2 || word_take;
    assign en1         = !r_v1 || en2;
    assign i_pix.ready = en1 && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_pix.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
        if (en1) begin
            r_eof1 <= i_pix.end_of_frame;
        end
        if (en2) begin
            r_eof2 <= r_eof1;
        end
    end

    assign lane_level[0] = i_pix.red;
    assign lane_level[1] = i_pix.green;
    assign lane_level[2] = i_pix.blue;
    assign lane_level[3] = i_pix.white;

    // four identical scaling lanes, one per color channel
    for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
        rlbs_scale_lane u_lane (
            .i_clk    (i_clk),
            .i_en1    (en1),
            .i_en2    (en2),
            .i_level  (lane_level[g]),
            .i_bright (r_bright),
            .o_byte   (lane_byte[g])
        );
    end

    // merge in grbw wire order and shift out
    rlbs_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (r_v2),
        .i_green      (lane_byte[1]),
        .i_red        (lane_byte[0]),
        .i_blue       (lane_byte[2]),
        .i_white      (lane_byte[3]),
        .i_eof        (r_eof2),
        .o_word_take  (word_take),
        .o_sym        (o_sym)
    );

endmodule

### tb/sv/tb_rgbw_led_bit_serializer_core.sv
// ----------------------------------------------------------------------------
// tb_rgbw_led_bit_serializer_core
// self-checking bench: random-gap pixel driver, line symbol scoreboard
// against a brightness-scaling predictor, several brightness settings
// ----------------------------------------------------------------------------
module tb_rgbw_led_bit_serializer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rlbs_pkg::*;

    // nothing accepted on either channel for this many cycles ends the run
    localparam int STALL_LIMIT   = 3000;
    // receiver hold-off length, long enough to fill both lane stages
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PCT      = 30;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_PIXELS  = 70;
    // quiet cycles after the last expected beat before the next step
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] white;
        logic              eof;
    } t_pixel;

    typedef struct packed {
        t_sym symbol;
        logic last;
    } t_line_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CHAN_W-1:0] i_cfg_wdata;

    rlbs_pix_if pix ();
    rlbs_sym_if sym ();

    // stimulus and scoreboard state
    t_pixel            pixel_q[$];      // pixels waiting to be offered
    t_line_beat        line_sym_q[$];   // predicted symbol beats, oldest first
    logic [CHAN_W-1:0] bright_pct;      // bench copy of the brightness register
    bit                steady;          // no idling on either side while set
    bit                hold_req;        // ask the receiver for one long hold-off
    bit                hold_done;
    int                hold_cycles;
    int                fail_cnt;
    int                quiet_cnt;

    rgbw_led_bit_serializer_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix),
        .o_sym       (sym)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // level * percent / 100, truncated, saturating at full scale
    function automatic logic [CHAN_W-1:0] scale_level(input logic [CHAN_W-1:0] level,
                                                      input logic [CHAN_W-1:0] pct);
        int unsigned prod;
        prod = (int'(level) * int'(pct)) / 100;
        return (prod > 255) ? CHAN_MAX : prod[CHAN_W-1:0];
    endfunction

    // green, red, blue, white, each msb first; eof pixels add one reset gap
    task automatic push_pixel_symbols(input t_pixel px);
        logic [WORD_W-1:0] word;
        t_line_beat        beat;
        word = {scale_level(px.green, bright_pct), scale_level(px.red, bright_pct),
                scale_level(px.blue, bright_pct), scale_level(px.white, bright_pct)};
        for (int i = WORD_W - 1; i >= 0; i--) begin
            beat.symbol = word[i] ? SYM_ONE : SYM_ZERO;
            beat.last   = !px.eof && (i == 0);
            line_sym_q.push_back(beat);
        end
        if (px.eof) begin
            beat.symbol = SYM_GAP;
            beat.last   = 1'b1;
            line_sym_q.push_back(beat);
        end
    endtask

    // ------------------------------------------------------------------------
    // pixel driver: offers queued pixels with random gaps, predicts on accept
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : pix_driver
        t_pixel px;
        t_pixel nxt;
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
        end else begin
            if (pix.valid && pix.ready) begin
                px.red   = pix.red;
                px.green = pix.green;
                px.blue  = pix.blue;
                px.white = pix.white;
                px.eof   = pix.end_of_frame;
                push_pixel_symbols(px);
            end
            // a beat still waiting for ready keeps valid and payload as they are
            if (!pix.valid || pix.ready) begin
                if (pixel_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = pixel_q.pop_front();
                    pix.red          <= nxt.red;
                    pix.green        <= nxt.green;
                    pix.blue         <= nxt.blue;
                    pix.white        <= nxt.white;
                    pix.end_of_frame <= nxt.eof;
                    pix.valid        <= 1'b1;
                end else begin
                    pix.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // symbol receiver: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sym.ready   <= 1'b0;
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            sym.ready   <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done   <= 1'b1;
            hold_cycles <= HOLD_CYCLES;
            sym.ready   <= 1'b0;
        end else begin
            sym.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // symbol monitor: each accepted beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_line_beat want;
        if (i_rst_n && sym.valid && sym.ready) begin
            if (line_sym_q.size() == 0) begin
                $error("unexpected symbol beat: symbol=%0d last=%0d", sym.symbol, sym.last);
                fail_cnt++;
            end else begin
                want = line_sym_q.pop_front();
                if (sym.symbol !== want.symbol) begin
                    $error("symbol mismatch: expected %0d, actual %0d", want.symbol, sym.symbol);
                    fail_cnt++;
                end
                if (sym.last !== want.last) begin
                    $error("last mismatch: expected %0d, actual %0d", want.last, sym.last);
                    fail_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any beat on either channel
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix.valid && pix.ready) || (sym.valid && sym.ready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    // ------------------------------------------------------------------------
    // sequence helpers
    // ------------------------------------------------------------------------
    task automatic queue_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                               input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] w,
                               input logic eof);
        t_pixel px;
        px = '{red: r, green: g, blue: b, white: w, eof: eof};
        pixel_q.push_back(px);
    endtask

    // mostly uniform levels, with the extremes drawn more often
    function automatic logic [CHAN_W-1:0] rand_level();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return CHAN_MAX;
        return CHAN_W'($urandom_range(255));
    endfunction

    task automatic queue_random_pixels(input int n);
        for (int i = 0; i < n; i++) begin
            // roughly one frame end in four pixels
            queue_pixel(rand_level(), rand_level(), rand_level(), rand_level(),
                        $urandom_range(3) == 0);
        end
    endtask

    // sender holds back until every predicted beat is out and the block is quiet
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pixel_q.size() != 0 || pix.valid || line_sym_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // register write only while drained
    task automatic write_brightness(input logic [CHAN_W-1:0] pct);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= pct;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        bright_pct  = pct;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [CHAN_W-1:0] pct;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        pix.valid        = 1'b0;
        pix.red          = '0;
        pix.green        = '0;
        pix.blue         = '0;
        pix.white        = '0;
        pix.end_of_frame = 1'b0;
        sym.ready        = 1'b0;
        bright_pct       = BRIGHT_RESET;
        steady           = 1'b0;
        hold_req         = 1'b0;
        fail_cnt         = 0;
        quiet_cnt        = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // brightness left at its reset value
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        queue_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        wait_drained();

        // unity scale: one channel at a time pins the green-red-blue-white order, then mixed patterns
        write_brightness(8'd100);
        queue_pixel(8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_pixel(8'h00, 8'hFF, 8'h00, 8'h00, 1'b0);
        queue_pixel(8'h00, 8'h00, 8'hFF, 8'h00, 1'b0);
        queue_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1);
        queue_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0);
        queue_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1);
        queue_pixel(8'h01, 8'h80, 8'h7F, 8'hFE, 1'b0);
        queue_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        wait_drained();

        // products above full scale saturate instead of wrapping
        write_brightness(8'd255);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        queue_pixel(8'd100, 8'd101, 8'd99, 8'd40, 1'b0);
        queue_pixel(8'd39, 8'd1, 8'd0, 8'd102, 1'b1);
        wait_drained();

        // zero brightness: every bit symbol is a zero
        write_brightness(8'd0);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_pixel(8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b1);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: pct = CHAN_W'($urandom_range(1, 99));
                1: pct = 8'd100;
                2: pct = CHAN_W'($urandom_range(101, 254));
                3: pct = 8'd255;
                4: pct = 8'd1;
                default: pct = CHAN_W'($urandom_range(255));
            endcase
            write_brightness(pct);
            // one long receiver hold-off while the sender keeps offering
            if (ph == 1)
                hold_req = 1'b1;
            // one phase runs back to back on both sides
            steady = (ph == 2);
            queue_random_pixels(PHASE_PIXELS);
            wait_drained();
        end
        steady = 1'b0;

        if (fail_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### rgbw_led_bit_serializer_core.f
rtl/rlbs_pkg.sv
rtl/rlbs_pix_if.sv
rtl/rlbs_sym_if.sv
rtl/rlbs_scale_lane.sv
rtl/rlbs_serializer.sv
rtl/rgbw_led_bit_serializer_core.sv
tb/sv/tb_rgbw_led_bit_serializer_core.sv
